// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- src/ctmcu_pkg.sv -----
// Package for the CTMC uniformization block: sequencer states, field widths
// and fixed-point constants. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ctmcu_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int MAX_DIM_DEF     = 16;

   localparam int IDX_W     = 4;
   localparam int RATE_W    = 32;
   localparam int ENTRY_W   = 2 * IDX_W + RATE_W;
   localparam int UF_W      = 16;
   localparam int BOUND_W   = 40;
   localparam int PROD_W    = UF_W + RATE_W;
   localparam int QBITS     = 32;
   localparam int DIV_CNT_W = $clog2(QBITS);
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   localparam logic [UF_W-1:0]   UF_RESET = 16'd256;
   localparam logic [RATE_W-1:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [RATE_W-1:0] PROB_MAX = 32'h7FFF_FFFF;
   localparam logic [RATE_W-1:0] PROB_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BOUND,
      ST_READ,
      ST_SETUP,
      ST_DIV,
      ST_FIN
   } state_type;

   // Magnitude of a two's complement rate; the most negative value gives 2^31.
   function automatic logic [RATE_W-1:0] rate_mag(input logic [RATE_W-1:0] v);
      rate_mag = v[RATE_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

`default_nettype wire

// ----- src/ctmc_uniformization.sv -----
// Top level of the CTMC uniformization block: entry store, rate bound and a
// bit-serial divider under one sequencer. Depends on ctmcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Generator entries (row, col, signed Q16.16 rate) arrive one transfer per
// cycle on the req_ channel and are written to an internal store of
// MAX_ENTRIES words; entries with an index at or above MAX_DIM, or arriving
// when the store is full, are dropped. The largest absolute diagonal is kept
// as entries arrive. The transfer marked by req_tlast starts the output burst:
// the bound state forms the bound (the uniformisation factor times the maximum
// diagonal, Q24.16),
// then every stored entry is replayed in arrival order and divided by that
// bound with a restoring divider that retires one quotient bit per cycle.
// A divided entry passes through store read, set-up, 32 divider steps and
// result; an entry whose quotient is known to overflow, and every entry of
// a burst with a zero bound, skips the divider. The input
// is not ready during the burst. The result register decouples the divider
// from the rsp_ side, so the next entry is divided while a result waits, and
// the block is ready for the next matrix while the final result waits. A zero
// bound gives the identity with zero_bound set. csr_wr_en writes the
// uniformisation factor (unsigned Q8.8); write it only while no burst is
// pending. The store needs
// no clearing pass after reset: only entries written for the current matrix
// are ever read.
module ctmc_uniformization
   import ctmcu_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int MAX_DIM     = MAX_DIM_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: row[3:0], col[7:4], rate[39:8]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   // rsp_tdata: out_row[3:0], out_col[7:4], prob[39:8], rate_bound[79:40]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: zero_bound[0], saturated[1]
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [UF_W-1:0]       csr_wr_data
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // Sequencer
   state_type state_ff, state_in;

   // Control registers
   logic [UF_W-1:0]    uf_ff, uf_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [RATE_W-1:0]  max_ff, max_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [BOUND_W-1:0] bound_ff, bound_in;
   logic               zb_ff, zb_in;
   logic               neg_ff, neg_in;
   logic               diag_ff, diag_in;
   logic               ovf_ff, ovf_in;
   logic [BOUND_W-1:0] rem_ff, rem_in;
   logic [QBITS-1:0]   dlo_ff, dlo_in;
   logic [QBITS-1:0]   quo_ff, quo_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic               rsp_last_ff, rsp_last_in;

   // Entry store and its registered read port
   logic [ENTRY_W-1:0] entry_mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0] ent_ff;

   // Decoded control
   logic req_acc;
   logic store_en;
   logic out_free;
   logic last_ent;

   // Input fields
   logic [IDX_W-1:0]  in_row, in_col;
   logic [RATE_W-1:0] in_rate, in_mag;

   // Replayed entry fields
   logic [IDX_W-1:0]  e_row, e_col;
   logic [RATE_W-1:0] e_rate, e_mag;
   logic [BOUND_W-1:0] e_head;

   // Datapath helpers
   logic [PROD_W-1:0]  prod;
   logic [BOUND_W:0]   shifted;
   logic [BOUND_W+1:0] trial;
   logic signed [RATE_W+2:0] q_ext, p_sum;
   logic [RATE_W-1:0]  prob;
   logic               sat;

   assign in_row  = req_tdata[IDX_W-1:0];
   assign in_col  = req_tdata[2*IDX_W-1:IDX_W];
   assign in_rate = req_tdata[ENTRY_W-1:2*IDX_W];
   assign in_mag  = rate_mag(in_rate);

   assign e_row  = ent_ff[ENTRY_W-1:ENTRY_W-IDX_W];
   assign e_col  = ent_ff[RATE_W+IDX_W-1:RATE_W];
   assign e_rate = ent_ff[RATE_W-1:0];
   assign e_mag  = rate_mag(e_rate);
   // Top 30 bits of mag * 2^30 above the 32 quotient bits: the first remainder
   assign e_head = {{(BOUND_W-RATE_W+2){1'b0}}, e_mag[RATE_W-1:2]};

   assign prod = PROD_W'(uf_ff) * PROD_W'(max_ff);

   // One restoring step: shift in the next dividend bit, try the subtract
   assign shifted = {rem_ff, dlo_ff[QBITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, bound_ff};

   // Signed result before clipping: +-q, plus 1.0 on the diagonal
   assign q_ext = $signed({3'b000, quo_ff});
   always_comb begin
      p_sum = neg_ff ? -q_ext : q_ext;
      if (diag_ff) begin
         p_sum = p_sum + $signed({3'b000, ONE_Q30});
      end
   end

   always_comb begin
      prob = p_sum[RATE_W-1:0];
      sat  = 1'b0;
      if (zb_ff) begin
         prob = diag_ff ? ONE_Q30 : '0;
      end else if (ovf_ff) begin
         // Quotient of 2^32 or more: clips whatever the diagonal adds
         prob = neg_ff ? PROB_MIN : PROB_MAX;
         sat  = 1'b1;
      end else if (!p_sum[RATE_W+2] && (p_sum[RATE_W+1:RATE_W-1] != 3'b000)) begin
         prob = PROB_MAX;
         sat  = 1'b1;
      end else if (p_sum[RATE_W+2] && (p_sum[RATE_W+1:RATE_W-1] != 3'b111)) begin
         prob = PROB_MIN;
         sat  = 1'b1;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            state_in = (count_ff == '0) ? ST_LOAD : ST_READ;
         end
         ST_READ: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            if (zb_ff || (e_head >= bound_ff)) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = last_ent ? ST_LOAD : ST_READ;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Decoded outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign req_acc  = req_tvalid && req_tready;
   assign store_en = req_acc
                  && ({28'd0, in_row} < 32'(MAX_DIM))
                  && ({28'd0, in_col} < 32'(MAX_DIM))
                  && (count_ff < CW'(MAX_ENTRIES));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_ent = ((CW'(idx_ff) + CW'(1)) == count_ff);

   // Datapath next values
   always_comb begin
      uf_in       = uf_ff;
      count_in    = count_ff;
      max_in      = max_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      bound_in    = bound_ff;
      zb_in       = zb_ff;
      neg_in      = neg_ff;
      diag_in     = diag_ff;
      ovf_in      = ovf_ff;
      rem_in      = rem_ff;
      dlo_in      = dlo_ff;
      quo_in      = quo_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_wr_en) begin
         uf_in = csr_wr_data;
      end

      // Drop the result once the far side has taken it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Store the entry and track the largest diagonal
      if (store_en) begin
         count_in = count_ff + CW'(1);
         if ((in_row == in_col) && (in_mag > max_ff)) begin
            max_in = in_mag;
         end
      end

      case (state_ff)
         ST_BOUND: begin
            bound_in = prod[PROD_W-1:PROD_W-BOUND_W];
            zb_in    = (prod[PROD_W-1:PROD_W-BOUND_W] == '0);
            idx_in   = '0;
            if (count_ff == '0) begin
               max_in = '0;
            end
         end
         ST_SETUP: begin
            neg_in  = e_rate[RATE_W-1];
            diag_in = (e_row == e_col);
            ovf_in  = (e_head >= bound_ff);
            rem_in  = e_head;
            dlo_in  = {e_mag[1:0], {(QBITS-2){1'b0}}};
            quo_in  = '0;
            cnt_in  = DIV_CNT_W'(QBITS - 1);
         end
         ST_DIV: begin
            if (!trial[BOUND_W+1]) begin
               rem_in = trial[BOUND_W-1:0];
               quo_in = {quo_ff[QBITS-2:0], 1'b1};
            end else begin
               rem_in = shifted[BOUND_W-1:0];
               quo_in = {quo_ff[QBITS-2:0], 1'b0};
            end
            dlo_in = {dlo_ff[QBITS-2:0], 1'b0};
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {bound_ff, prob, e_col, e_row};
               rsp_user_in  = {sat, zb_ff};
               rsp_last_in  = last_ent;
               if (last_ent) begin
                  count_in = '0;
                  max_in   = '0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         uf_ff        <= UF_RESET;
         count_ff     <= '0;
         max_ff       <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         uf_ff        <= uf_in;
         count_ff     <= count_in;
         max_ff       <= max_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bound_ff    <= bound_in;
      zb_ff       <= zb_in;
      neg_ff      <= neg_in;
      diag_ff     <= diag_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      dlo_ff      <= dlo_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Entry store: write in arrival order, read the replay index every cycle
   always_ff @(posedge clock) begin
      if (store_en) begin
         entry_mem[count_ff[AW-1:0]] <= {in_row, in_col, in_rate};
      end
      ent_ff <= entry_mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/ctmcu_checker.sv -----
// Port-level checker for the CTMC uniformization block, bound to the top
// level. Depends on ctmcu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ctmcu_checker
   import ctmcu_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   logic [IDX_W-1:0]   row, col;
   logic [RATE_W-1:0]  prob;
   logic [BOUND_W-1:0] bound;

   assign row   = rsp_tdata[IDX_W-1:0];
   assign col   = rsp_tdata[2*IDX_W-1:IDX_W];
   assign prob  = rsp_tdata[ENTRY_W-1:2*IDX_W];
   assign bound = rsp_tdata[RSP_DATA_W-1:ENTRY_W];

   // Hold a stalled transfer
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // The zero flag follows the bound carried with the result
   `ASSERT_IMPL(a_zero_flag, clock, reset, rsp_tvalid, (bound == '0) == rsp_tuser[0])

   // A zero bound gives the identity and never clips
   `ASSERT_IMPL(a_identity, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1] && (prob == ((row == col) ? ONE_Q30 : '0)))

   // A clipped result sits at one end of the range
   `ASSERT_IMPL(a_sat_end, clock, reset, rsp_tvalid && rsp_tuser[1], (prob == PROB_MAX) || (prob == PROB_MIN))

endmodule

bind ctmc_uniformization ctmcu_checker u_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
